// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the ring block
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_ALWAYS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");

`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rst, expr)
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ===== hdl/uetbr_pkg.sv =====
// ----------------------------------------------------------------------------
// uetbr_pkg
// types, codes and defaults shared by the uart byte ring block
// ----------------------------------------------------------------------------
package uetbr_pkg;

   localparam int RX_DEPTH_DEF = 64;
   localparam int TX_DEPTH_DEF = 64;

   localparam logic [1:0] CMD_LINE_BYTE  = 2'd0;
   localparam logic [1:0] CMD_DRAIN      = 2'd1;
   localparam logic [1:0] CMD_HOST_WRITE = 2'd2;
   localparam logic [1:0] CMD_TX_READY   = 2'd3;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_NO_DATA = 2'd1;
   localparam logic [1:0] STATUS_TX_FULL = 2'd2;
   localparam logic [1:0] STATUS_INVALID = 2'd3;

   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] data_byte;
      logic       parity_err;
      logic       overrun_err;
      logic       framing_err;
      logic       first_of_burst;
      logic [6:0] burst_len;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [7:0] read_byte;
      logic       read_valid;
      logic       last;
      logic       rx_restart;
      logic [7:0] tx_byte;
      logic       tx_valid;
      logic       tx_irq_enable;
      logic [5:0] tx_free;
      logic [5:0] rx_count;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic exec;
      logic drain_begin;
      logic drain_emit;
   } ctrl_type;

   // datapath to controller
   typedef struct packed {
      logic [1:0] cmd;
      logic       rx_empty;
      logic       clean_none;
      logic       drain_at_last;
      logic       out_free;
   } stat_type;

endpackage

// ===== hdl/uetbr_ctrl.sv =====
// ----------------------------------------------------------------------------
// uetbr_ctrl
// sequencer: takes one request, runs it, while the result slot is free walks a drain one byte per cycle
// ----------------------------------------------------------------------------
module uetbr_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  uetbr_pkg::stat_type stat,
   output uetbr_pkg::ctrl_type ctrl
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_DRAIN
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      ctrl     = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               ctrl.capture = 1'b1;
               state_in     = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (stat.cmd == uetbr_pkg::CMD_DRAIN && !stat.rx_empty && !stat.clean_none) begin
               ctrl.drain_begin = 1'b1;
               state_in         = ST_DRAIN;
            end else if (stat.out_free) begin
               ctrl.exec = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         ST_DRAIN: begin
            if (stat.out_free) begin
               ctrl.drain_emit = 1'b1;
               if (stat.drain_at_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== hdl/uetbr_dpath.sv =====
// ----------------------------------------------------------------------------
// uetbr_dpath
// request register, receive and transmit rings, result register
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module uetbr_dpath #(
   parameter int RX_DEPTH = uetbr_pkg::RX_DEPTH_DEF,
   parameter int TX_DEPTH = uetbr_pkg::TX_DEPTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  uetbr_pkg::req_type  req_data,
   input  uetbr_pkg::ctrl_type ctrl,
   output uetbr_pkg::stat_type stat,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output uetbr_pkg::rsp_type  rsp_data
);

   localparam int RX_AW = $clog2(RX_DEPTH);
   localparam int TX_AW = $clog2(TX_DEPTH);
   localparam int BW    = TX_AW + 8;
   localparam int FW    = (TX_AW > 6) ? TX_AW : 6;

   function automatic logic [RX_AW-1:0] rx_inc(input logic [RX_AW-1:0] p);
      rx_inc = (p == RX_AW'(RX_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [TX_AW-1:0] tx_inc(input logic [TX_AW-1:0] p);
      tx_inc = (p == TX_AW'(TX_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [RX_AW-1:0] rx_used(input logic [RX_AW-1:0] w,
                                                 input logic [RX_AW-1:0] r);
      rx_used = (w >= r) ? (w - r)
                         : RX_AW'({1'b0, w} + (RX_AW+1)'(RX_DEPTH) - {1'b0, r});
   endfunction

   function automatic logic [TX_AW-1:0] tx_used(input logic [TX_AW-1:0] w,
                                                 input logic [TX_AW-1:0] r);
      tx_used = (w >= r) ? (w - r)
                         : TX_AW'({1'b0, w} + (TX_AW+1)'(TX_DEPTH) - {1'b0, r});
   endfunction

   logic [7:0] rx_mem [RX_DEPTH];
   logic [7:0] tx_mem [TX_DEPTH];

   uetbr_pkg::req_type req_ff, req_in;
   uetbr_pkg::rsp_type rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic [RX_AW-1:0] rx_wp_ff, rx_wp_in, rx_rp_ff, rx_rp_in;
   logic [RX_AW-1:0] cur_ff, cur_in, err_ptr_ff, err_ptr_in;
   logic             err_seen_ff, err_seen_in;
   logic [TX_AW-1:0] tx_wp_ff, tx_wp_in, tx_rp_ff, tx_rp_in;
   logic             tx_idle_ff, tx_idle_in;
   logic             rejected_ff, rejected_in;
   logic [7:0]       rx_rdata_ff, tx_rdata_ff;

   logic             rx_we, tx_we, err_any, rx_room, out_free;
   logic [7:0]       rx_wdata;
   logic [RX_AW-1:0] drain_start, rx_used_nx;
   logic [TX_AW-1:0] tx_used_ff, tx_used_nx, tx_free_nx;
   logic [FW-1:0]    tx_free_w;

   assign err_any     = req_ff.parity_err | req_ff.overrun_err | req_ff.framing_err;
   assign rx_wdata    = err_any ? 8'h00 : req_ff.data_byte;
   assign rx_room     = rx_used(rx_wp_ff, rx_rp_ff) < RX_AW'(RX_DEPTH - 1);
   assign drain_start = err_seen_ff ? rx_inc(err_ptr_ff) : rx_rp_ff;
   assign tx_used_ff  = tx_used(tx_wp_ff, tx_rp_ff);
   assign out_free    = !rsp_valid_ff || rsp_ready;

   assign stat.cmd           = req_ff.cmd;
   assign stat.rx_empty      = (rx_wp_ff == rx_rp_ff);
   assign stat.clean_none    = (drain_start == rx_wp_ff);
   assign stat.drain_at_last = (rx_inc(cur_ff) == rx_wp_ff);
   assign stat.out_free      = out_free;

   always_comb begin
      req_in      = ctrl.capture ? req_data : req_ff;
      rx_wp_in    = rx_wp_ff;
      rx_rp_in    = rx_rp_ff;
      cur_in      = cur_ff;
      err_ptr_in  = err_ptr_ff;
      err_seen_in = err_seen_ff;
      tx_wp_in    = tx_wp_ff;
      tx_rp_in    = tx_rp_ff;
      tx_idle_in  = tx_idle_ff;
      rejected_in = rejected_ff;
      rx_we       = 1'b0;
      tx_we       = 1'b0;
      rsp_in      = '0;

      if (ctrl.exec) begin
         rsp_in.last = 1'b1;
         unique case (req_ff.cmd)
            uetbr_pkg::CMD_LINE_BYTE: begin
               rsp_in.rx_restart = err_any;
               if (rx_room) begin
                  rx_we    = 1'b1;
                  rx_wp_in = rx_inc(rx_wp_ff);
                  if (err_any) begin
                     err_ptr_in  = rx_wp_ff;
                     err_seen_in = 1'b1;
                  end
               end
            end
            uetbr_pkg::CMD_DRAIN: begin
               if (stat.rx_empty) begin
                  rsp_in.status = uetbr_pkg::STATUS_NO_DATA;
               end else begin
                  rx_rp_in    = rx_wp_ff;
                  err_seen_in = 1'b0;
               end
            end
            uetbr_pkg::CMD_HOST_WRITE: begin
               if (req_ff.first_of_burst) begin
                  if (req_ff.burst_len == 7'd0) begin
                     rsp_in.status = uetbr_pkg::STATUS_INVALID;
                     rejected_in   = 1'b1;
                  end else if (BW'(req_ff.burst_len) + BW'(tx_used_ff) >
                               BW'(TX_DEPTH - 1)) begin
                     rsp_in.status = uetbr_pkg::STATUS_TX_FULL;
                     rejected_in   = 1'b1;
                  end else begin
                     rejected_in = 1'b0;
                     tx_we       = 1'b1;
                  end
               end else if (!rejected_ff) begin
                  if (tx_used_ff < TX_AW'(TX_DEPTH - 1)) begin
                     tx_we = 1'b1;
                  end else begin
                     rsp_in.status = uetbr_pkg::STATUS_TX_FULL;
                  end
               end
               if (tx_we) begin
                  tx_wp_in   = tx_inc(tx_wp_ff);
                  tx_idle_in = 1'b0;
               end
            end
            uetbr_pkg::CMD_TX_READY: begin
               if (tx_used_ff != '0) begin
                  rsp_in.tx_byte  = tx_rdata_ff;
                  rsp_in.tx_valid = 1'b1;
                  tx_rp_in        = tx_inc(tx_rp_ff);
               end else begin
                  tx_idle_in = 1'b1;
               end
            end
            default: begin
               rsp_in.status = uetbr_pkg::STATUS_OK;
            end
         endcase
      end

      if (ctrl.drain_begin) begin
         rx_rp_in    = rx_wp_ff;
         err_seen_in = 1'b0;
         cur_in      = drain_start;
      end

      if (ctrl.drain_emit) begin
         cur_in            = rx_inc(cur_ff);
         rsp_in.read_byte  = rx_rdata_ff;
         rsp_in.read_valid = 1'b1;
         rsp_in.last       = stat.drain_at_last;
      end

      rx_used_nx           = rx_used(rx_wp_in, rx_rp_in);
      tx_used_nx           = tx_used(tx_wp_in, tx_rp_in);
      tx_free_nx           = TX_AW'(TX_DEPTH - 1) - tx_used_nx;
      tx_free_w            = FW'(tx_free_nx);
      rsp_in.tx_irq_enable = !tx_idle_in;
      rsp_in.tx_free       = (tx_free_w > FW'(63)) ? 6'd63 : tx_free_w[5:0];
      rsp_in.rx_count      = 6'(rx_used_nx);

      if (ctrl.exec || ctrl.drain_emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rx_wp_ff     <= '0;
         rx_rp_ff     <= '0;
         cur_ff       <= '0;
         err_ptr_ff   <= '0;
         err_seen_ff  <= 1'b0;
         tx_wp_ff     <= '0;
         tx_rp_ff     <= '0;
         tx_idle_ff   <= 1'b1;
         rejected_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rx_wp_ff     <= rx_wp_in;
         rx_rp_ff     <= rx_rp_in;
         cur_ff       <= cur_in;
         err_ptr_ff   <= err_ptr_in;
         err_seen_ff  <= err_seen_in;
         tx_wp_ff     <= tx_wp_in;
         tx_rp_ff     <= tx_rp_in;
         tx_idle_ff   <= tx_idle_in;
         rejected_ff  <= rejected_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      if (ctrl.exec || ctrl.drain_emit) begin
         rsp_ff <= rsp_in;
      end
   end

   // ring storage, read data registered
   always_ff @(posedge clock) begin
      if (rx_we) begin
         rx_mem[rx_wp_ff] <= rx_wdata;
      end
      rx_rdata_ff <= rx_mem[cur_in];
   end

   always_ff @(posedge clock) begin
      if (tx_we) begin
         tx_mem[tx_wp_ff] <= req_ff.data_byte;
      end
      tx_rdata_ff <= tx_mem[tx_rp_ff];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `ASSERT_ALWAYS(a_one_cmd, clock, reset, !(ctrl.exec && (ctrl.drain_emit || ctrl.drain_begin)))
   `ASSERT_NEXT(a_drain_empties, clock, reset, ctrl.drain_begin, rx_wp_ff == rx_rp_ff)
   `ASSERT_IMPLY(a_tx_no_overfill, clock, reset, tx_we, tx_used_ff < TX_AW'(TX_DEPTH - 1))
   `ASSERT_IMPLY(a_emit_needs_slot, clock, reset, ctrl.drain_emit || ctrl.exec, out_free)

endmodule

// ===== hdl/uart_error_tagged_byte_rings.sv =====
// ----------------------------------------------------------------------------
// uart_error_tagged_byte_rings
// receive and transmit byte rings between a uart and a host
// ----------------------------------------------------------------------------
// req channel carries one request: line byte, host drain, host write byte or
// transmitter ready. rsp channel returns the results, one per request except a
// drain, which gives one result per clean byte after the last error entry
// (last marks the final one), or a single result when there is nothing to give.
// a request is taken only when the previous one is done; a result register
// sits on rsp, so the next request is taken while a result waits there.
// a single-result request passes the request register, then the exec state,
// then the result register. a drain gives one byte per cycle, while the
// result register is free or being read, out of the receive ring memory
// read port. when rsp_ready is low the block holds the result and waits,
// nothing is dropped. synchronous reset empties both rings, marks the
// transmitter idle and clears the burst reject flag; no clearing pass.
// ----------------------------------------------------------------------------
module uart_error_tagged_byte_rings #(
   parameter int RX_DEPTH = uetbr_pkg::RX_DEPTH_DEF,
   parameter int TX_DEPTH = uetbr_pkg::TX_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  uetbr_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output uetbr_pkg::rsp_type rsp_data
);

   uetbr_pkg::ctrl_type ctrl;
   uetbr_pkg::stat_type stat;

   uetbr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .ctrl      (ctrl)
   );

   uetbr_dpath #(
      .RX_DEPTH (RX_DEPTH),
      .TX_DEPTH (TX_DEPTH)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .ctrl      (ctrl),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
